// ----- hw/rtl/priority_run_queue_assert.svh -----
// Assertion macros used by the port-level checker of the priority run queue.
`ifndef PRIORITY_RUN_QUEUE_ASSERT_SVH
`define PRIORITY_RUN_QUEUE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PRQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PRQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/prq_pkg.sv -----
// Types, sizes and helper functions shared by the priority run queue modules.
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

    // Sizes of the queue.
    localparam int NUM_LEVELS = 16;
    localparam int NUM_TASKS  = 256;

    // Field widths of requests and results.
    localparam int TASK_ID_W = 8;
    localparam int LEVEL_W   = 4;
    localparam int COUNT_W   = 9;

    // Index widths into the level and task stores.
    localparam int LVL_IW  = $clog2(NUM_LEVELS);
    localparam int TASK_IW = $clog2(NUM_TASKS);

    // Request kinds.
    typedef enum logic {
        KIND_ENQUEUE = 1'b0,
        KIND_DEQUEUE = 1'b1
    } kind_t;

    // One request from the input side.
    typedef struct packed {
        kind_t                  kind;
        logic [TASK_ID_W-1:0]   task_id;
        logic [LEVEL_W-1:0]     level;
    } req_t;

    // One result toward the output side.
    typedef struct packed {
        logic                   granted;
        logic                   none_ready;
        logic [TASK_ID_W-1:0]   picked_id;
        logic [LEVEL_W-1:0]     picked_level;
        logic [COUNT_W-1:0]     ready_count;
        logic [LEVEL_W-1:0]     best_hint;
    } rsp_t;

    // Outcome of the search for the most urgent non-empty level.
    typedef struct packed {
        logic               found;
        logic [LVL_IW-1:0]  idx;
    } first_t;

    // Priority encoder: lowest set bit wins.
    function automatic first_t find_first(input logic [NUM_LEVELS-1:0] nonempty);
        first_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                res.found = 1'b1;
                res.idx   = LVL_IW'(i);
            end
        end
        return res;
    endfunction

    // Levels beyond the last one fold onto the least urgent level.
    function automatic logic [LVL_IW-1:0] clamp_level(input logic [LEVEL_W-1:0] level);
        logic [LVL_IW-1:0] res;
        if (32'(level) >= NUM_LEVELS) begin
            res = LVL_IW'(NUM_LEVELS - 1);
        end else begin
            res = LVL_IW'(level);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/prq_core.sv -----
// Queue state and the single-pass enqueue and dequeue logic.
`timescale 1ns / 1ps
`default_nettype none

module prq_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fire,
    input  wire prq_pkg::req_t req,
    output prq_pkg::rsp_t      rsp
);

    // Per-level list pointers and occupancy.
    logic [prq_pkg::TASK_IW-1:0]    head_reg [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::TASK_IW-1:0]    head_next [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::TASK_IW-1:0]    tail_reg [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::TASK_IW-1:0]    tail_next [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::NUM_LEVELS-1:0] nonempty_reg;
    logic [prq_pkg::NUM_LEVELS-1:0] nonempty_next;

    // Per-task queued flags, count and hint.
    logic [prq_pkg::NUM_TASKS-1:0]  queued_reg;
    logic [prq_pkg::NUM_TASKS-1:0]  queued_next;
    logic [prq_pkg::COUNT_W-1:0]    total_reg;
    logic [prq_pkg::COUNT_W-1:0]    total_next;
    logic [prq_pkg::LEVEL_W-1:0]    hint_reg;
    logic [prq_pkg::LEVEL_W-1:0]    hint_next;

    // A head update whose new value is still coming out of the link memory.
    logic                           pend_reg;
    logic                           pend_next;
    logic [prq_pkg::LVL_IW-1:0]     pend_lvl_reg;
    logic [prq_pkg::LVL_IW-1:0]     pend_lvl_next;

    // Link memory port signals.
    logic                           link_wr_en;
    logic [prq_pkg::TASK_IW-1:0]    link_wr_addr;
    logic [prq_pkg::TASK_IW-1:0]    link_wr_data;
    logic                           link_rd_en;
    logic [prq_pkg::TASK_IW-1:0]    link_rd_addr;
    logic [prq_pkg::TASK_IW-1:0]    link_rd_data;

    // Decoded request.
    logic [prq_pkg::TASK_IW-1:0]    head_eff [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::LVL_IW-1:0]     enq_lvl;
    logic [prq_pkg::TASK_IW-1:0]    enq_idx;
    logic                           enq_ok;
    prq_pkg::first_t                first;
    logic [prq_pkg::TASK_IW-1:0]    deq_h;
    logic                           deq_last;
    logic                           is_enq;

    // The next-task link of every queued task.
    prq_ram #(
        .WIDTH (prq_pkg::TASK_IW),
        .DEPTH (prq_pkg::NUM_TASKS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    // Heads as seen by the current request, with a pending update forwarded.
    always_comb begin
        for (int i = 0; i < prq_pkg::NUM_LEVELS; i++) begin
            if (pend_reg && (pend_lvl_reg == prq_pkg::LVL_IW'(i))) begin
                head_eff[i] = link_rd_data;
            end else begin
                head_eff[i] = head_reg[i];
            end
        end
    end

    // Request decode and level search.
    always_comb begin
        is_enq   = (req.kind == prq_pkg::KIND_ENQUEUE);
        enq_lvl  = prq_pkg::clamp_level(req.level);
        enq_idx  = prq_pkg::TASK_IW'(req.task_id);
        enq_ok   = (32'(req.task_id) < prq_pkg::NUM_TASKS) && !queued_reg[enq_idx];
        first    = prq_pkg::find_first(nonempty_reg);
        deq_h    = head_eff[first.idx];
        deq_last = (deq_h == tail_reg[first.idx]);
    end

    // Link memory accesses: append on enqueue, fetch the successor on dequeue.
    always_comb begin
        link_wr_en   = fire && is_enq && enq_ok && nonempty_reg[enq_lvl];
        link_wr_addr = tail_reg[enq_lvl];
        link_wr_data = enq_idx;
        link_rd_en   = fire && !is_enq && first.found && !deq_last;
        link_rd_addr = deq_h;
    end

    // Next state and result of the current request.
    always_comb begin
        head_next     = head_eff;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        queued_next   = queued_reg;
        total_next    = total_reg;
        hint_next     = hint_reg;
        pend_next     = 1'b0;
        pend_lvl_next = pend_lvl_reg;
        rsp           = '0;

        if (fire) begin
            unique case (req.kind)
                prq_pkg::KIND_ENQUEUE: begin
                    if (enq_ok) begin
                        if (32'(enq_lvl) < 32'(hint_reg)) begin
                            hint_next = prq_pkg::LEVEL_W'(enq_lvl);
                        end
                        if (!nonempty_reg[enq_lvl]) begin
                            head_next[enq_lvl] = enq_idx;
                        end
                        tail_next[enq_lvl]     = enq_idx;
                        nonempty_next[enq_lvl] = 1'b1;
                        queued_next[enq_idx]   = 1'b1;
                        total_next             = total_reg + 1'b1;
                    end
                end
                prq_pkg::KIND_DEQUEUE: begin
                    if (!first.found) begin
                        rsp.none_ready = 1'b1;
                    end else begin
                        if (deq_last) begin
                            nonempty_next[first.idx] = 1'b0;
                        end else begin
                            pend_next     = 1'b1;
                            pend_lvl_next = first.idx;
                        end
                        queued_next[deq_h] = 1'b0;
                        total_next         = total_reg - 1'b1;
                        hint_next          = prq_pkg::LEVEL_W'(first.idx);
                        rsp.granted        = 1'b1;
                        rsp.picked_id      = prq_pkg::TASK_ID_W'(deq_h);
                        rsp.picked_level   = prq_pkg::LEVEL_W'(first.idx);
                    end
                end
                default: begin
                end
            endcase
        end

        rsp.ready_count = total_next;
        rsp.best_hint   = hint_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= '0;
            queued_reg   <= '0;
            total_reg    <= '0;
            hint_reg     <= '0;
            pend_reg     <= 1'b0;
        end else begin
            nonempty_reg <= nonempty_next;
            queued_reg   <= queued_next;
            total_reg    <= total_next;
            hint_reg     <= hint_next;
            pend_reg     <= pend_next;
        end
    end

    // Pointers, meaningful only while their level is non-empty.
    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        pend_lvl_reg <= pend_lvl_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/priority_run_queue.sv -----
// Top level of the priority run queue: request and result registers around the core.
//
// Strict-priority ready queue of task identifiers with one linked list per level,
// level 0 most urgent. Every request returns exactly one result. The block takes
// one request per clock cycle while the result side accepts results. A request
// taken into the request register passes through the core into the result register
// once that register is free or being drained, and its result is then offered.
// The sustained rate is one request per cycle while the result side keeps up. That
// figure is set by the single pass from the request register to the result register;
// the successor of a dequeued task comes out of the registered read port of the link
// memory and is forwarded straight to the next request. The per-task queued flags
// clear at reset, so no clearing pass is needed and the block takes requests right
// after reset. An enqueue of a task already queued changes nothing. A dequeue with
// every level empty returns none_ready.
`timescale 1ns / 1ps
`default_nettype none

module priority_run_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // task_id [7:0], level [11:8], zero [15:12]
    input  wire logic [0:0]  s_tuser,  // kind [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // picked_id [7:0], picked_level [11:8],
                                       // ready_count [20:12], best_hint [24:21], zero [31:25]
    output logic [1:0]       m_tuser   // granted [0], none_ready [1]
);

    logic          in_valid_reg;
    logic          in_valid_next;
    prq_pkg::req_t in_req_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    prq_pkg::rsp_t out_rsp_reg;
    prq_pkg::rsp_t core_rsp;
    logic          fire;

    // A request is processed when the result register is free or being drained.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    prq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (in_req_reg),
        .rsp     (core_rsp)
    );

    // Valid flags of the request and result registers.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the request and result registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.kind    <= prq_pkg::kind_t'(s_tuser[0]);
            in_req_reg.task_id <= s_tdata[7:0];
            in_req_reg.level   <= s_tdata[11:8];
        end
        if (fire) begin
            out_rsp_reg <= core_rsp;
        end
    end

    // Result packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_rsp_reg.best_hint, out_rsp_reg.ready_count,
                       out_rsp_reg.picked_level, out_rsp_reg.picked_id};
    assign m_tuser  = {out_rsp_reg.none_ready, out_rsp_reg.granted};

endmodule

`default_nettype wire

// ----- hw/rtl/prq_checker.sv -----
// Port-level assertions for the priority run queue and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "priority_run_queue_assert.svh"

module prq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A result either grants a task or reports an empty queue, never both.
    `PRQ_ASSERT_IMP(a_grant_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "granted with none_ready")

    // A granted task moves the hint to the level it came from.
    `PRQ_ASSERT_IMP(a_hint_follows, m_tvalid && m_tuser[0], m_tdata[24:21] == m_tdata[11:8], "hint differs from picked level")

    // An empty queue holds no tasks.
    `PRQ_ASSERT_IMP(a_empty_count, m_tvalid && m_tuser[1], m_tdata[20:12] == 9'd0, "none_ready with tasks counted")

    // A stalled result stays in place.
    `PRQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind priority_run_queue prq_checker u_prq_checker (.*);

`default_nettype wire

// ----- tb/sv/prq_checker.sv -----
// Checker for the priority run queue: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module prq_tb_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,  // task_id [7:0], level [11:8], zero [15:12]
    input  wire logic [0:0]  s_tuser,  // kind [0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,  // picked_id [7:0], picked_level [11:8],
                                       // ready_count [20:12], best_hint [24:21], zero [31:25]
    input  wire logic [1:0]  m_tuser,  // granted [0], none_ready [1]
    output int               fail_count,
    output int               pending
);

    // Shadow of the queue: one linked list per level plus per-task flags.
    logic [prq_pkg::TASK_ID_W-1:0]  lvl_head [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::TASK_ID_W-1:0]  lvl_tail [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::NUM_LEVELS-1:0] lvl_busy;
    logic [prq_pkg::TASK_ID_W-1:0]  succ [prq_pkg::NUM_TASKS];
    logic [prq_pkg::NUM_TASKS-1:0]  task_queued;
    logic [prq_pkg::COUNT_W-1:0]    ready_total;
    logic [prq_pkg::LEVEL_W-1:0]    hint;

    // Results still owed by the block, oldest first.
    prq_pkg::rsp_t expected_q[$];
    int            mismatches = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Applies one request to the shadow queue and returns the result it should produce.
    function automatic prq_pkg::rsp_t schedule_request(input prq_pkg::req_t r);
        prq_pkg::rsp_t res;
        int            lvl;
        int            pick;
        int            h;
        res = '0;
        if (r.kind == prq_pkg::KIND_ENQUEUE) begin
            lvl = (int'(r.level) >= prq_pkg::NUM_LEVELS) ? prq_pkg::NUM_LEVELS - 1
                                                         : int'(r.level);
            // A task that is already waiting is left where it is.
            if (!task_queued[r.task_id]) begin
                if (lvl < int'(hint)) begin
                    hint = prq_pkg::LEVEL_W'(lvl);
                end
                if (lvl_busy[lvl]) begin
                    succ[lvl_tail[lvl]] = r.task_id;
                end else begin
                    lvl_head[lvl] = r.task_id;
                end
                lvl_tail[lvl]          = r.task_id;
                lvl_busy[lvl]          = 1'b1;
                task_queued[r.task_id] = 1'b1;
                ready_total            = ready_total + 1'b1;
            end
        end else begin
            // The most urgent non-empty level gives up its head.
            pick = -1;
            for (int l = prq_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
                if (lvl_busy[l]) begin
                    pick = l;
                end
            end
            if (pick < 0) begin
                res.none_ready = 1'b1;
            end else begin
                h = int'(lvl_head[pick]);
                if (h == int'(lvl_tail[pick])) begin
                    lvl_busy[pick] = 1'b0;
                end else begin
                    lvl_head[pick] = succ[h];
                end
                task_queued[h]   = 1'b0;
                ready_total      = ready_total - 1'b1;
                hint             = prq_pkg::LEVEL_W'(pick);
                res.granted      = 1'b1;
                res.picked_id    = prq_pkg::TASK_ID_W'(h);
                res.picked_level = prq_pkg::LEVEL_W'(pick);
            end
        end
        res.ready_count = ready_total;
        res.best_hint   = hint;
        return res;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Both channels are sampled at the clock edge at which a request or result moves.
    always @(posedge aclk) begin
        prq_pkg::req_t r;
        prq_pkg::rsp_t exp_rsp;
        if (!aresetn) begin
            lvl_busy    = '0;
            task_queued = '0;
            ready_total = '0;
            hint        = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    exp_rsp = expected_q.pop_front();
                    check_field("granted", exp_rsp.granted, m_tuser[0]);
                    check_field("none_ready", exp_rsp.none_ready, m_tuser[1]);
                    check_field("picked_id", exp_rsp.picked_id, m_tdata[7:0]);
                    check_field("picked_level", exp_rsp.picked_level, m_tdata[11:8]);
                    check_field("ready_count", exp_rsp.ready_count, m_tdata[20:12]);
                    check_field("best_hint", exp_rsp.best_hint, m_tdata[24:21]);
                end
            end
            if (s_tvalid && s_tready) begin
                r.kind    = prq_pkg::kind_t'(s_tuser[0]);
                r.task_id = s_tdata[7:0];
                r.level   = s_tdata[11:8];
                expected_q.push_back(schedule_request(r));
            end
        end
        fail_count <= mismatches;
        pending    <= expected_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the priority run queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;

    // Random idling on each side; cleared for a long back-to-back stretch.
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    int random_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    priority_run_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    prq_tb_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The result side stalls about a fifth of the time while idling is on.
    always @(posedge aclk) begin
        m_tready <= rx_idle_en ? ($urandom_range(0, 99) >= 20) : 1'b1;
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input prq_pkg::kind_t k, input logic [7:0] id,
                                input logic [3:0] lvl);
        int gap;
        if (tx_idle_en && $urandom_range(0, 99) < 20) begin
            gap = $urandom_range(1, 2);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, lvl, id};
        s_tuser  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Enqueues every task id once in a shuffled order, then empties the queue again.
    task automatic fill_and_empty();
        int perm [prq_pkg::NUM_TASKS];
        int j;
        int t;
        for (int i = 0; i < prq_pkg::NUM_TASKS; i++) begin
            perm[i] = i;
        end
        for (int i = prq_pkg::NUM_TASKS - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < prq_pkg::NUM_TASKS; i++) begin
            send_request(prq_pkg::KIND_ENQUEUE, 8'(perm[i]), 4'($urandom_range(0, 15)));
        end
        // Repeats while the queue is full must change nothing.
        repeat (4) send_request(prq_pkg::KIND_ENQUEUE, 8'($urandom), 4'($urandom));
        repeat (prq_pkg::NUM_TASKS + 4) begin
            send_request(prq_pkg::KIND_DEQUEUE, 8'($urandom), 4'($urandom));
        end
        random_sent += 2 * prq_pkg::NUM_TASKS + 8;
    endtask

    // Mixed requests; a narrow id and level pool makes repeats and level ties common.
    task automatic run_mixed_burst();
        int             seg_len;
        int             enq_pct;
        bit             narrow;
        prq_pkg::kind_t k;
        int             pct_choice [4];
        pct_choice = '{25, 50, 65, 85};
        seg_len    = $urandom_range(20, 80);
        enq_pct    = pct_choice[$urandom_range(0, 3)];
        narrow     = ($urandom_range(0, 2) == 0);
        repeat (seg_len) begin
            k = ($urandom_range(0, 99) < enq_pct) ? prq_pkg::KIND_ENQUEUE
                                                  : prq_pkg::KIND_DEQUEUE;
            if (narrow) begin
                send_request(k, 8'($urandom_range(0, 15)), 4'($urandom_range(0, 3)));
            end else begin
                send_request(k, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            end
        end
        random_sent += seg_len;
    endtask

    // Watchdog for a hung run.
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests: empty dequeue, extreme ids and levels, repeats, hint moves.
        send_request(prq_pkg::KIND_DEQUEUE, 8'h00, 4'h0);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h00, 4'hF);
        send_request(prq_pkg::KIND_ENQUEUE, 8'hFF, 4'h0);
        send_request(prq_pkg::KIND_ENQUEUE, 8'hAA, 4'hF);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h55, 4'h7);
        send_request(prq_pkg::KIND_ENQUEUE, 8'hFF, 4'h3);
        send_request(prq_pkg::KIND_DEQUEUE, 8'hFF, 4'hF);
        send_request(prq_pkg::KIND_DEQUEUE, 8'h00, 4'h0);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h01, 4'h9);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h02, 4'h4);
        send_request(prq_pkg::KIND_DEQUEUE, 8'h00, 4'h0);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h10, 4'h5);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h11, 4'h5);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h12, 4'h5);
        send_request(prq_pkg::KIND_DEQUEUE, 8'h00, 4'h0);
        send_request(prq_pkg::KIND_DEQUEUE, 8'h00, 4'h0);
        send_request(prq_pkg::KIND_ENQUEUE, 8'h10, 4'h2);
        repeat (8) send_request(prq_pkg::KIND_DEQUEUE, 8'h00, 4'h0);

        // Long stretch with no idling on either side.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        fill_and_empty();
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Random bursts, now and then letting every result come back first.
        while (random_sent < 1200) begin
            run_mixed_burst();
            if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
